// File: rtl/core/chm_pkg.sv
// Shared types and constants for the chained integer-key hash map.
// Used by the controller, the datapath and the top level; no dependencies.
package chm_pkg;

   localparam int NumBuckets  = 256;
   localparam int PoolEntries = 1024;
   localparam int BucketW     = $clog2(NumBuckets);
   localparam int IdxW        = $clog2(PoolEntries);
   localparam int LinkW       = $clog2(PoolEntries + 1);
   localparam int CountW      = 9;
   localparam int KeyW        = 32;
   localparam int ValW        = 32;
   localparam int ModSteps    = 32;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_STORE  = 1'b1;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic head_rd;
      logic head_take;
      logic entry_rd;
      logic entry_take;
      logic upd_value;
      logic append;
      logic set_result;
      logic [1:0] result_kind;
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic link_null;
      logic link_bad;
      logic key_hit;
      logic is_store;
      logic pool_full;
   } status_type;

   localparam logic [1:0] RES_MISS = 2'd0;
   localparam logic [1:0] RES_HIT  = 2'd1;
   localparam logic [1:0] RES_FULL = 2'd2;

endpackage

// File: rtl/core/chm_datapath.sv
// Datapath of the hash map: bit-serial modulo, head and pool memories, chain registers.
// Depends on chm_pkg.
module chm_datapath
   import chm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                in_type,
   input  logic [KeyW-1:0]     in_key,
   input  logic [ValW-1:0]     in_value,
   input  logic [CountW-1:0]   bucket_count,
   output logic                res_found,
   output logic [ValW-1:0]     res_value,
   output logic                res_full
);

   logic [LinkW-1:0]  head_mem [NumBuckets];
   logic [NumBuckets-1:0] head_vld_ff;
   logic [KeyW-1:0]   key_mem  [PoolEntries];
   logic [ValW-1:0]   val_mem  [PoolEntries];
   logic [LinkW-1:0]  next_mem [PoolEntries];

   logic              type_ff;
   logic [KeyW-1:0]   key_ff;
   logic [ValW-1:0]   value_ff;
   logic [KeyW-1:0]   mag_ff, mag_in;
   logic [CountW-1:0] rem_ff, rem_in;
   logic [CountW-1:0] div_ff;
   logic [5:0]        mcnt_ff;
   logic [BucketW-1:0] bucket;
   logic [LinkW-1:0]  head_rd_ff;
   logic              head_vrd_ff;
   logic [LinkW-1:0]  link_ff, last_ff;
   logic [LinkW-1:0]  used_ff;
   logic [LinkW-1:0]  steps_ff;
   logic [KeyW-1:0]   rd_key_ff;
   logic [ValW-1:0]   rd_val_ff;
   logic [LinkW-1:0]  rd_next_ff;
   logic [IdxW-1:0]   idx;
   logic [CountW:0]   trial;
   logic [CountW-1:0] div_sat;

   assign idx = IdxW'(link_ff - LinkW'(1));
   assign bucket = rem_ff[BucketW-1:0];

   always_comb begin
      div_sat = bucket_count;
      if (bucket_count == '0) div_sat = CountW'(1);
      if (bucket_count > CountW'(NumBuckets)) div_sat = CountW'(NumBuckets);
      trial = {rem_ff, mag_ff[KeyW-1]} - {1'b0, div_ff};
      mag_in = {mag_ff[KeyW-2:0], 1'b0};
      rem_in = trial[CountW] ? {rem_ff[CountW-2:0], mag_ff[KeyW-1]} : trial[CountW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= in_type;
         key_ff   <= in_key;
         value_ff <= in_value;
         mag_ff   <= in_key[KeyW-1] ? (~in_key + KeyW'(1)) : in_key;
         rem_ff   <= '0;
         div_ff   <= div_sat;
      end else if (cmd.mod_step) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
      if (cmd.head_rd) begin
         head_rd_ff <= head_mem[bucket];
      end
      if (cmd.entry_rd) begin
         rd_key_ff  <= key_mem[idx];
         rd_val_ff  <= val_mem[idx];
         rd_next_ff <= next_mem[idx];
      end
      if (cmd.upd_value) val_mem[idx] <= value_ff;
      if (cmd.append) begin
         key_mem[IdxW'(used_ff)]  <= key_ff;
         val_mem[IdxW'(used_ff)]  <= value_ff;
         next_mem[IdxW'(used_ff)] <= '0;
         if (last_ff == '0) head_mem[bucket] <= used_ff + LinkW'(1);
         else next_mem[IdxW'(last_ff - LinkW'(1))] <= used_ff + LinkW'(1);
      end
      if (cmd.set_result) begin
         res_found <= (cmd.result_kind == RES_HIT);
         res_full  <= (cmd.result_kind == RES_FULL);
         res_value <= (cmd.result_kind == RES_HIT && !type_ff) ? rd_val_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         used_ff     <= '0;
         mcnt_ff     <= '0;
         head_vrd_ff <= 1'b0;
      end else begin
         if (cmd.load) mcnt_ff <= '0;
         else if (cmd.mod_step) mcnt_ff <= mcnt_ff + 6'd1;
         if (cmd.head_rd) head_vrd_ff <= head_vld_ff[bucket];
         if (cmd.append) begin
            used_ff <= used_ff + LinkW'(1);
            if (last_ff == '0) head_vld_ff[bucket] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_take) begin
         link_ff  <= head_vrd_ff ? head_rd_ff : '0;
         last_ff  <= '0;
         steps_ff <= '0;
      end else if (cmd.entry_take) begin
         last_ff  <= link_ff;
         link_ff  <= rd_next_ff;
         steps_ff <= steps_ff + LinkW'(1);
      end
   end

   assign status.mod_done  = (mcnt_ff == 6'(ModSteps));
   assign status.link_null = (link_ff == '0);
   assign status.link_bad  = (link_ff > used_ff) || (steps_ff >= used_ff);
   assign status.key_hit   = (rd_key_ff == key_ff);
   assign status.is_store  = type_ff;
   assign status.pool_full = (used_ff >= LinkW'(PoolEntries));

endmodule

// File: rtl/core/chm_ctrl.sv
// Controller state machine of the hash map: sequences hash, chain walk and update.
// Depends on chm_pkg.
module chm_ctrl
   import chm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_MOD   = 8'b00000010,
      S_HEAD  = 8'b00000100,
      S_TAKE  = 8'b00001000,
      S_CHECK = 8'b00010000,
      S_READ  = 8'b00100000,
      S_CMP   = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_ready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (status.mod_done) state_in = S_HEAD;
            else cmd.mod_step = 1'b1;
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.head_take = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.link_null || status.link_bad) begin
               cmd.set_result = 1'b1;
               cmd.result_kind = RES_MISS;
               if (status.is_store) begin
                  if (status.pool_full) cmd.result_kind = RES_FULL;
                  else cmd.append = 1'b1;
               end
               state_in = S_OUT;
            end else begin
               cmd.entry_rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (status.key_hit) begin
               cmd.set_result = 1'b1;
               cmd.result_kind = RES_HIT;
               cmd.upd_value = status.is_store;
               state_in = S_OUT;
            end else begin
               cmd.entry_take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_READ: state_in = S_CHECK;
         S_OUT: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/core/chained_int_key_hash_map_unit.sv
// Top level of the chained integer-key hash map.
// Depends on chm_pkg, chm_ctrl and chm_datapath.
// One item is processed at a time. For an empty bucket the result is offered after the
// bit-serial bucket modulo (one key bit a cycle), the head read, the chain check and a
// register for the result. Each chain entry visited adds a read and a compare, and a hit
// skips the final chain check that a miss takes. The next item is accepted the cycle after
// the result leaves. No clearing pass is needed.
module chained_int_key_hash_map_unit
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[31:0], value[63:32]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // found[0], value_out[32:1], pool_full[33], zeros
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data  // bucket_count
);

   cmd_type         cmd;
   status_type      status;
   logic [CountW-1:0] bcount_ff;
   logic            found, full;
   logic [ValW-1:0] vout;

   always_ff @(posedge clock) begin
      if (reset) bcount_ff <= CountW'(NumBuckets);
      else if (csr_wr_en) bcount_ff <= csr_wr_data;
   end

   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_tvalid && req_tready),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   chm_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_type      (req_tuser),
      .in_key       (req_tdata[31:0]),
      .in_value     (req_tdata[63:32]),
      .bucket_count (bcount_ff),
      .res_found    (found),
      .res_value    (vout),
      .res_full     (full)
   );

   assign rsp_tdata = {6'd0, full, vout, found};

endmodule

// File: rtl/core/chm_checker.sv
// Port-level checker for the hash map unit, bound to the top level.
// Depends on no package.
module chm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[33])) else $error("found with full");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid) else $error("result too early");

endmodule

bind chained_int_key_hash_map_unit chm_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
